FILE: hdl/assert_macros.svh
// assert_macros.svh: assertion helpers shared by the glyph delta rle encoder rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre holds at an edge, post must hold at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: %m");

// pre holds at an edge, post must hold at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: %m");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

FILE: hdl/gdre_pkg.sv
// gdre_pkg: shared types and constants of the glyph delta rle encoder
// no dependencies; imported by every module of the block

package gdre_pkg;

  localparam int GLYPH_WIDTH_W = 9;
  localparam logic [GLYPH_WIDTH_W-1:0] GLYPH_WIDTH_RESET = 9'd1;

  // depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // one classified pixel: optional pair to close, optional literal to store,
  // optional end-of-glyph pair to flush (in that order)
  typedef struct packed {
    logic [7:0] t;
    logic       wr_en;
    logic [7:0] widx;
    logic       close;
    logic [7:0] a_zr;
    logic [7:0] a_lc;
    logic       eog;
    logic [7:0] b_zr;
    logic [7:0] b_lc;
  } cmd_t;

  // one coded byte from the back sequencer to the packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       step_last;
    logic       glyph_done;
  } byte_t;

endpackage

FILE: hdl/gdre_front.sv
// gdre_front: pixel intake, row delta transform and zero-run classification
// depends on gdre_pkg and assert_macros.svh; feeds commands to gdre_cmd_fifo
`include "assert_macros.svh"

module gdre_front import gdre_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int RUN_LIMIT = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               pixel_i,
  input  logic                     end_of_glyph_i,
  input  logic [GLYPH_WIDTH_W-1:0] glyph_width_i,
  input  logic                     cmd_full_i,
  output logic                     cmd_push_o,
  output cmd_t                     cmd_o
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CntW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (CntW > GLYPH_WIDTH_W) ? CntW : GLYPH_WIDTH_W;
  localparam logic [7:0] RunMax = 8'(RUN_LIMIT);

  typedef enum logic {FE_IDLE, FE_CODE} fe_state_e;
  typedef enum logic {PH_ZERO, PH_LIT} phase_e;

  fe_state_e       st_q, st_d;
  phase_e          ph_q, ph_d;
  logic [7:0]      zr_q, zr_d;
  logic [7:0]      lc_q, lc_d;
  logic [7:0]      prev_q;
  logic [CntW-1:0] col_cnt_q;
  logic            first_row_q;

  // stage two payload
  logic [7:0]      d_q;
  logic [7:0]      row_rd_q;
  logic [ColW-1:0] col_q;
  logic            first_q;
  logic            eog_q;

  logic [7:0]      row_store [MAX_WIDTH];

  logic            accept, fire;
  logic [CmpW-1:0] w_eff;
  logic            wrap;
  logic [ColW-1:0] col_a;
  logic [7:0]      left;
  logic [7:0]      t;
  cmd_t            cmd;

  assign accept     = push && (st_q == FE_IDLE);
  assign fire       = (st_q == FE_CODE) && !cmd_full_i;
  assign full       = (st_q == FE_CODE);
  assign cmd_push_o = fire;
  assign cmd_o      = cmd;

  // effective row width and column of the incoming pixel
  always_comb begin
    w_eff = CmpW'(glyph_width_i);
    if (glyph_width_i == '0) begin
      w_eff = CmpW'(1);
    end
    if (w_eff > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end
    wrap  = (CmpW'(col_cnt_q) >= w_eff);
    col_a = wrap ? '0 : col_cnt_q[ColW-1:0];
    left  = (col_a == '0) ? 8'd0 : prev_q;
  end

  // vertical difference and coder decision
  always_comb begin
    t     = first_q ? d_q : 8'(d_q - row_rd_q);
    cmd   = '0;
    cmd.t = t;
    zr_d  = zr_q;
    lc_d  = lc_q;
    ph_d  = ph_q;
    if (ph_q == PH_ZERO) begin
      if (t == 8'd0) begin
        if (zr_q < RunMax) begin
          zr_d = 8'(zr_q + 8'd1);
        end else begin
          cmd.close = 1'b1;
          cmd.a_zr  = zr_q;
          cmd.a_lc  = 8'd0;
          zr_d      = 8'd1;
        end
      end else begin
        cmd.wr_en = 1'b1;
        cmd.widx  = 8'd0;
        lc_d      = 8'd1;
        ph_d      = PH_LIT;
      end
    end else begin
      if (t == 8'd0) begin
        cmd.close = 1'b1;
        cmd.a_zr  = zr_q;
        cmd.a_lc  = lc_q;
        zr_d      = 8'd1;
        lc_d      = 8'd0;
        ph_d      = PH_ZERO;
      end else if (lc_q < RunMax) begin
        cmd.wr_en = 1'b1;
        cmd.widx  = lc_q;
        lc_d      = 8'(lc_q + 8'd1);
      end else begin
        cmd.close = 1'b1;
        cmd.a_zr  = zr_q;
        cmd.a_lc  = lc_q;
        zr_d      = 8'd0;
        cmd.wr_en = 1'b1;
        cmd.widx  = 8'd0;
        lc_d      = 8'd1;
      end
    end
    // end of glyph flushes the pending pair and restarts the coder
    if (eog_q) begin
      cmd.eog  = 1'b1;
      cmd.b_zr = zr_d;
      cmd.b_lc = (ph_d == PH_ZERO) ? 8'd0 : lc_d;
      zr_d     = 8'd0;
      lc_d     = 8'd0;
      ph_d     = PH_ZERO;
    end
  end

  always_comb begin
    st_d = st_q;
    if (accept) begin
      st_d = FE_CODE;
    end else if (fire) begin
      st_d = FE_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= FE_IDLE;
      ph_q        <= PH_ZERO;
      zr_q        <= 8'd0;
      lc_q        <= 8'd0;
      prev_q      <= 8'd0;
      col_cnt_q   <= '0;
      first_row_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (accept) begin
        if (end_of_glyph_i) begin
          prev_q      <= 8'd0;
          col_cnt_q   <= '0;
          first_row_q <= 1'b1;
        end else begin
          prev_q      <= pixel_i;
          col_cnt_q   <= CntW'(col_a) + CntW'(1);
          first_row_q <= wrap ? 1'b0 : first_row_q;
        end
      end
      if (fire) begin
        ph_q <= ph_d;
        zr_q <= zr_d;
        lc_q <= lc_d;
      end
    end
  end

  // stage two payload and row store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_q      <= 8'(pixel_i - left);
      col_q    <= col_a;
      first_q  <= wrap ? 1'b0 : first_row_q;
      eog_q    <= end_of_glyph_i;
      row_rd_q <= row_store[col_a];
    end
    if (fire) begin
      row_store[col_q] <= t;
    end
  end

  `ASSERT_IMPLIES(a_zero_phase_no_lits, clk_i, rst_ni, ph_q == PH_ZERO, lc_q == 8'd0)
  `ASSERT_IMPLIES(a_counts_capped, clk_i, rst_ni, ph_q == PH_LIT, lc_q != 8'd0 && lc_q <= RunMax && zr_q <= RunMax)
  `ASSERT_NEXT(a_eog_restarts_rows, clk_i, rst_ni, accept && end_of_glyph_i, col_cnt_q == '0 && first_row_q)

endmodule

FILE: hdl/gdre_cmd_fifo.sv
// gdre_cmd_fifo: short command queue that decouples front and back
// depends on gdre_pkg

module gdre_cmd_fifo import gdre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= CMD_PTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= CMD_PTR_W'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/gdre_back.sv
// gdre_back: pair sequencer, holds the literal store and emits coded bytes
// depends on gdre_pkg and assert_macros.svh; drains gdre_cmd_fifo, feeds gdre_packer
`include "assert_macros.svh"

module gdre_back import gdre_pkg::*; #(
  parameter int RUN_LIMIT = 255
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_empty_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output byte_t byte_o,
  input  logic  byte_ready_i
);

  localparam int LitAw = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;

  typedef enum logic [2:0] {
    BE_IDLE, BE_A_ZR, BE_A_LC, BE_A_LIT, BE_B_ZR, BE_B_LC, BE_B_LIT
  } be_state_e;

  be_state_e        st_q, st_d;
  cmd_t             cmd_q;
  logic [LitAw-1:0] idx_q, idx_d;
  logic [7:0]       lit_rd_q;
  logic [7:0]       lit_store [RUN_LIMIT];

  logic             fire, pair_end, in_lit;
  logic             lit_we;
  logic [LitAw-1:0] lit_wa;
  logic [7:0]       lit_wd;
  logic [7:0]       idx8;

  assign idx8   = 8'(idx_q);
  assign in_lit = (st_q == BE_A_LIT) || (st_q == BE_B_LIT);
  assign fire   = byte_o.valid && byte_ready_i;

  // byte selection and sequencing
  always_comb begin
    byte_o    = '0;
    pair_end  = 1'b0;
    cmd_pop_o = 1'b0;
    lit_we    = 1'b0;
    lit_wa    = cmd_q.widx[LitAw-1:0];
    lit_wd    = cmd_q.t;
    st_d      = st_q;
    unique case (st_q)
      BE_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          // a literal with no pair before it is stored right away
          lit_we    = cmd_i.wr_en && !cmd_i.close;
          lit_wa    = cmd_i.widx[LitAw-1:0];
          lit_wd    = cmd_i.t;
          if (cmd_i.close) begin
            st_d = BE_A_ZR;
          end else if (cmd_i.eog) begin
            st_d = BE_B_ZR;
          end
        end
      end
      BE_A_ZR: begin
        byte_o.valid = 1'b1;
        byte_o.data  = cmd_q.a_zr;
        if (fire) begin
          st_d = BE_A_LC;
        end
      end
      BE_A_LC, BE_A_LIT: begin
        byte_o.valid = 1'b1;
        if (st_q == BE_A_LC) begin
          byte_o.data = cmd_q.a_lc;
          pair_end    = (cmd_q.a_lc == 8'd0);
        end else begin
          byte_o.data = lit_rd_q;
          pair_end    = (idx8 == 8'(cmd_q.a_lc - 8'd1));
        end
        byte_o.step_last = pair_end && !cmd_q.eog;
        if (fire) begin
          if (pair_end) begin
            // store the literal that follows the closed pair
            lit_we = cmd_q.wr_en;
            st_d   = cmd_q.eog ? BE_B_ZR : BE_IDLE;
          end else begin
            st_d = BE_A_LIT;
          end
        end
      end
      BE_B_ZR: begin
        byte_o.valid = 1'b1;
        byte_o.data  = cmd_q.b_zr;
        if (fire) begin
          st_d = BE_B_LC;
        end
      end
      BE_B_LC, BE_B_LIT: begin
        byte_o.valid = 1'b1;
        if (st_q == BE_B_LC) begin
          byte_o.data = cmd_q.b_lc;
          pair_end    = (cmd_q.b_lc == 8'd0);
        end else begin
          byte_o.data = lit_rd_q;
          pair_end    = (idx8 == 8'(cmd_q.b_lc - 8'd1));
        end
        byte_o.step_last  = pair_end;
        byte_o.glyph_done = pair_end;
        if (fire) begin
          st_d = pair_end ? BE_IDLE : BE_B_LIT;
        end
      end
      default: begin
        st_d = BE_IDLE;
      end
    endcase
  end

  // literal read address runs one step ahead of the emitted byte
  always_comb begin
    idx_d = '0;
    if (in_lit) begin
      idx_d = (fire && !pair_end) ? LitAw'(idx_q + 1'b1) : idx_q;
    end
  end

  // state and current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BE_IDLE;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // literal store
  always_ff @(posedge clk_i) begin
    if (lit_we) begin
      lit_store[lit_wa] <= lit_wd;
    end
    lit_rd_q <= lit_store[idx_d];
  end

  `ASSERT_IMPLIES(a_lit_needs_count, clk_i, rst_ni, st_q == BE_A_LIT, cmd_q.a_lc != 8'd0 && idx8 < cmd_q.a_lc)
  `ASSERT_IMPLIES(a_flush_lit_index, clk_i, rst_ni, st_q == BE_B_LIT, cmd_q.b_lc != 8'd0 && idx8 < cmd_q.b_lc)
  `ASSERT_IMPLIES(a_flush_only_on_eog, clk_i, rst_ni, st_q == BE_B_ZR || st_q == BE_B_LC || st_q == BE_B_LIT, cmd_q.eog)

endmodule

FILE: hdl/gdre_packer.sv
// gdre_packer: packs up to eight coded bytes per result, holds the result register
// depends on gdre_pkg; fed by gdre_back

module gdre_packer import gdre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_t       byte_i,
  output logic        byte_ready_o,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] packed_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        run_last_o,
  output logic        glyph_done_o
);

  logic [63:0] word_q, word_next;
  logic [2:0]  cnt_q;
  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic [3:0]  out_cnt_q;
  logic        out_last_q, out_done_q;
  logic        flush, out_free, fire;

  assign flush        = (cnt_q == 3'd7) || byte_i.step_last;
  assign out_free     = !out_valid_q || pop;
  assign byte_ready_o = !flush || out_free;
  assign fire         = byte_i.valid && byte_ready_o;

  assign empty          = !out_valid_q;
  assign packed_bytes_o = out_word_q;
  assign byte_count_o   = out_cnt_q;
  assign run_last_o     = out_last_q;
  assign glyph_done_o   = out_done_q;

  // place the byte in its lane
  always_comb begin
    word_next = word_q;
    word_next[{cnt_q, 3'b000} +: 8] = byte_i.data;
  end

  // partial word and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (flush) begin
          word_q <= '0;
          cnt_q  <= '0;
        end else begin
          word_q <= word_next;
          cnt_q  <= cnt_q + 3'd1;
        end
      end
      // a popped result is replaced only by a flushed word
      if (fire && flush) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && flush) begin
      out_word_q <= word_next;
      out_cnt_q  <= {1'b0, cnt_q} + 4'd1;
      out_last_q <= byte_i.step_last;
      out_done_q <= byte_i.glyph_done;
    end
  end

endmodule

FILE: hdl/glyph_delta_rle_encoder.sv
// Glyph delta + zero-run encoder, top level.
// Input queue side: push/full carries pixel_i and end_of_glyph_i; a transaction
// completes when push is high and full is low. Result queue side: empty/pop;
// the oldest result sits on packed_bytes_o, byte_count_o, run_last_o and
// glyph_done_o while empty is low and is taken when pop is high.
// Config: cfg_valid_i/cfg_ready_o write glyph_width (ready is always high);
// write it only while the block is idle. Reset value is 1.
// The front takes a pixel only while idle and holds full high until the pixel's
// command is in the queue; it reads the row store on acceptance and writes the
// result back when the command is passed on. The back pops a command only when
// idle, once the last one's bytes are out; a 4-entry command queue absorbs
// bursts. A closed pair's bytes go from the front's stage-two registers through
// the command queue and the back's command register to the packer's result register.
// A stalled receiver fills the result register, then the packer and back stop,
// the queue fills and full rises; nothing is dropped.
// Reset clears all control state; the row store and literal store have no
// clearing pass and are valid once written.
// depends on gdre_pkg, gdre_front, gdre_cmd_fifo, gdre_back, gdre_packer

module glyph_delta_rle_encoder import gdre_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int RUN_LIMIT = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               pixel_i,
  input  logic                     end_of_glyph_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [63:0]              packed_bytes_o,
  output logic [3:0]               byte_count_o,
  output logic                     run_last_o,
  output logic                     glyph_done_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [GLYPH_WIDTH_W-1:0] cfg_data_i
);

  logic [GLYPH_WIDTH_W-1:0] glyph_width_q;
  logic                     cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t                     cmd_in, cmd_head;
  byte_t                    byte_s;
  logic                     byte_ready;

  assign cfg_ready_o = 1'b1;

  // width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q <= GLYPH_WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      glyph_width_q <= cfg_data_i;
    end
  end

  gdre_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .RUN_LIMIT (RUN_LIMIT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .pixel_i        (pixel_i),
    .end_of_glyph_i (end_of_glyph_i),
    .glyph_width_i  (glyph_width_q),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  gdre_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  gdre_back #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .byte_o       (byte_s),
    .byte_ready_i (byte_ready)
  );

  gdre_packer u_packer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_s),
    .byte_ready_o   (byte_ready),
    .empty          (empty),
    .pop            (pop),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .run_last_o     (run_last_o),
    .glyph_done_o   (glyph_done_o)
  );

endmodule
